>>> rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, codes and types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 13;
    localparam int SAT_W     = 8;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    // divider geometry: numerator = {remainder part, quotient part}
    localparam int DIV_DEN_W = 9;
    localparam int DIV_QUO_W = 11;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;

    // hue offsets in 1/16 degree
    localparam logic signed [13:0] HUE_SECT_STEP = 14'sd1920;
    localparam logic signed [13:0] HUE_HALF_BIAS = 14'sd960;
    localparam logic signed [13:0] HUE_FULL_TURN = 14'sd5760;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [CHAN_W-1:0] bright;
        sector_t           sector;
        logic              grey;
    } rhc_side_t;

endpackage

>>> rtl/rhc_div_pipe.sv
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhc_div_pipe
    import rhc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 ce,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_QUO_W-1:0] quo
);

    logic [DIV_NUM_W-1:0] acc_reg  [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] acc_next [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_QUO_W];

    for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_stage
        logic [DIV_NUM_W-1:0] acc_src;
        logic [DIV_DEN_W-1:0] den_src;
        logic [DIV_DEN_W:0]   trial;
        logic                 qbit;

        if (k == 0) begin : g_first
            assign acc_src = num;
            assign den_src = den;
        end else begin : g_rest
            assign acc_src = acc_reg[k-1];
            assign den_src = den_reg[k-1];
        end

        always_comb begin
            trial = acc_src[DIV_NUM_W-1 -: DIV_DEN_W+1];
            qbit  = 1'b0;
            if (trial >= {1'b0, den_src}) begin
                trial = trial - {1'b0, den_src};
                qbit  = 1'b1;
            end
            acc_next[k] = {trial[DIV_DEN_W-1:0], acc_src[DIV_QUO_W-2:0], qbit};
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                acc_reg[k] <= acc_next[k];
                den_reg[k] <= den_src;
            end
        end
    end

    assign quo = acc_reg[DIV_QUO_W-1][DIV_QUO_W-1:0];

endmodule

>>> rtl/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Streaming RGB to HSV pixel converter with exact rounded fixed-point output.
// ----------------------------------------------------------------------------
// One pixel enters per clock while s_tready is high. Four stages find
// max/min, sector and the division operands, the two 11-stage restoring
// dividers (hue and saturation, run side by side) set most of the
// latency, and one output register follows. A two-entry output buffer lets
// the pipeline keep taking pixels while a result waits; s_tready falls only
// once both entries are full, and then the whole pipeline holds.
module rgb_to_hsv_converter_unit
    import rhc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // hue[12:0], saturation[20:13],
                                          // brightness[28:21], zero[31:29]
);

    logic ce;

    // stage A: input capture
    logic              a_valid_reg;
    logic [CHAN_W-1:0] a_red_reg, a_green_reg, a_blue_reg;

    // stage B: max, min, sector, signed difference
    logic              b_valid_reg;
    logic [CHAN_W-1:0] b_max_reg, b_min_reg;
    sector_t           b_sector_reg;
    logic signed [8:0] b_diff_reg;
    logic [CHAN_W-1:0] b_max_next, b_min_next;
    sector_t           b_sector_next;
    logic signed [8:0] b_diff_next;

    // stage C: delta and shifted difference
    logic              c_valid_reg;
    logic [CHAN_W-1:0] c_max_reg, c_delta_reg;
    logic [8:0]        c_shift_reg;
    sector_t           c_sector_reg;
    logic [CHAN_W-1:0] c_delta_next;
    logic signed [9:0] c_shift_wide;

    // stage D: division operands
    logic                 d_valid_reg;
    logic [DIV_NUM_W-1:0] d_num_h_reg, d_num_s_reg;
    logic [DIV_DEN_W-1:0] d_den_h_reg, d_den_s_reg;
    rhc_side_t            d_side_reg;

    // divider-aligned sideband
    logic      v_reg    [DIV_QUO_W];
    rhc_side_t side_reg [DIV_QUO_W];

    logic [DIV_QUO_W-1:0] quo_h, quo_s;

    // result and output buffer
    logic signed [13:0]  hue_wide, hue_wrap;
    logic [HUE_W-1:0]    hue_val;
    logic [SAT_W-1:0]    sat_val;
    logic [M_DATA_W-1:0] pipe_data;
    logic                pipe_valid;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_red_reg   <= s_tdata[7:0];
            a_green_reg <= s_tdata[15:8];
            a_blue_reg  <= s_tdata[23:16];
        end
    end

    // stage B: red wins ties, then green
    always_comb begin
        b_min_next = a_red_reg;
        if (a_green_reg < b_min_next) begin
            b_min_next = a_green_reg;
        end
        if (a_blue_reg < b_min_next) begin
            b_min_next = a_blue_reg;
        end
        if (a_red_reg >= a_green_reg && a_red_reg >= a_blue_reg) begin
            b_sector_next = SECT_RED;
            b_max_next    = a_red_reg;
            b_diff_next   = $signed({1'b0, a_green_reg}) - $signed({1'b0, a_blue_reg});
        end else if (a_green_reg >= a_blue_reg) begin
            b_sector_next = SECT_GREEN;
            b_max_next    = a_green_reg;
            b_diff_next   = $signed({1'b0, a_blue_reg}) - $signed({1'b0, a_red_reg});
        end else begin
            b_sector_next = SECT_BLUE;
            b_max_next    = a_blue_reg;
            b_diff_next   = $signed({1'b0, a_red_reg}) - $signed({1'b0, a_green_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_max_reg    <= b_max_next;
            b_min_reg    <= b_min_next;
            b_sector_reg <= b_sector_next;
            b_diff_reg   <= b_diff_next;
        end
    end

    // stage C: shift difference into 0..2*delta
    assign c_delta_next = b_max_reg - b_min_reg;
    assign c_shift_wide = $signed({b_diff_reg[8], b_diff_reg})
                        + $signed({2'b00, c_delta_next});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_max_reg    <= b_max_reg;
            c_delta_reg  <= c_delta_next;
            c_shift_reg  <= c_shift_wide[8:0];
            c_sector_reg <= b_sector_reg;
        end
    end

    // stage D: hue num = 1920*shift + delta, den = 2*delta
    //          sat num = 510*delta + max,   den = 2*max
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_num_h_reg <= {c_shift_reg, 11'b0} - {4'b0, c_shift_reg, 7'b0}
                         + {12'b0, c_delta_reg};
            d_num_s_reg <= {3'b0, c_delta_reg, 9'b0} - {11'b0, c_delta_reg, 1'b0}
                         + {12'b0, c_max_reg};
            d_den_h_reg <= {c_delta_reg, 1'b0};
            d_den_s_reg <= {c_max_reg, 1'b0};
            d_side_reg  <= '{bright: c_max_reg, sector: c_sector_reg,
                             grey: (c_delta_reg == '0)};
        end
    end

    rhc_div_pipe u_div_hue (
        .aclk (aclk),
        .ce   (ce),
        .num  (d_num_h_reg),
        .den  (d_den_h_reg),
        .quo  (quo_h)
    );

    rhc_div_pipe u_div_sat (
        .aclk (aclk),
        .ce   (ce),
        .num  (d_num_s_reg),
        .den  (d_den_s_reg),
        .quo  (quo_s)
    );

    for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_side
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (ce) begin
                    v_reg[k] <= d_valid_reg;
                end
            end
            always_ff @(posedge aclk) begin
                if (ce) begin
                    side_reg[k] <= d_side_reg;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (ce) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (ce) begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // final hue: quotient - 960 + sector offset, wrapped into one turn
    always_comb begin
        hue_wide = $signed({3'b000, quo_h}) - HUE_HALF_BIAS;
        case (side_reg[DIV_QUO_W-1].sector)
            SECT_RED:   hue_wide = hue_wide;
            SECT_GREEN: hue_wide = hue_wide + HUE_SECT_STEP;
            SECT_BLUE:  hue_wide = hue_wide + HUE_SECT_STEP + HUE_SECT_STEP;
            default:    hue_wide = hue_wide;
        endcase
        hue_wrap = (hue_wide < 0) ? hue_wide + HUE_FULL_TURN : hue_wide;
        if (side_reg[DIV_QUO_W-1].grey) begin
            hue_val = '0;
            sat_val = '0;
        end else begin
            hue_val = hue_wrap[HUE_W-1:0];
            sat_val = quo_s[SAT_W-1:0];
        end
    end

    assign pipe_valid = v_reg[DIV_QUO_W-1];
    assign pipe_data  = {3'b000, side_reg[DIV_QUO_W-1].bright, sat_val, hue_val};

    // output register with skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            if (pipe_valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_data;
            end
        end else begin
            out_valid_next = pipe_valid;
            out_data_next  = pipe_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/rhc_port_checker.sv
// ----------------------------------------------------------------------------
// rhc_port_checker
// Port-level checks on the RGB to HSV converter's result stream.
// ----------------------------------------------------------------------------
module rhc_port_checker
    import rhc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // hold a stalled transaction
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction dropped or changed while stalled");

    // come out of reset with no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:0] < 13'd5760)
        else $error("hue beyond one full turn");

    // grey pixels alone give zero saturation, and their hue is zero
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:13] == 8'd0 |-> m_tdata[12:0] == 13'd0)
        else $error("zero saturation with nonzero hue");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:29] == 3'b000)
        else $error("padding bits of result not zero");

endmodule

bind rgb_to_hsv_converter_unit rhc_port_checker u_rhc_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
